// ----- design/hchp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and character tables for the cookie header parser.
// Depends on nothing; every other file in the design but hchp_fifo uses it.
package hchp_pkg;

	localparam int COUNT_WIDTH_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Role of a byte within the header.
	typedef enum logic [2:0] {
		ROLE_NONE      = 3'd0,
		ROLE_VERSION   = 3'd1,
		ROLE_NAME      = 3'd2,
		ROLE_VALUE     = 3'd3,
		ROLE_ATTR_NAME = 3'd4,
		ROLE_ATTR_VAL  = 3'd5
	} role_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_INCOMPL   = 3'd1,
		ERR_EXP_VER   = 3'd2,
		ERR_EXP_EQ    = 3'd3,
		ERR_EXP_SEMI  = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		KIND_PATH    = 2'd0,
		KIND_DOMAIN  = 2'd1,
		KIND_PORT    = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [2:0] KW_LAST = 3'd6;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] char_out;
		role_t      char_role;
		logic       cookie_start;
		logic       name_done;
		logic       value_done;
		logic       attr_done;
		kind_t      attr_kind;
		err_t       error_code;
		logic       header_end;
		logic [7:0] cookie_index;
	} out_t;

	// A byte after classification by the front end.
	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] ucase;
		logic       last;
		logic       blank;
		logic       dollar;
		logic       semi;
		logic       comma;
		logic       eq;
		logic       quote;
	} class_t;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		upcase = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
	endfunction

	// Letters of the VERSION keyword.
	function automatic logic [7:0] kw_char(input logic [2:0] i);
		case (i)
			3'd0:    kw_char = 8'h56;
			3'd1:    kw_char = 8'h45;
			3'd2:    kw_char = 8'h52;
			3'd3:    kw_char = 8'h53;
			3'd4:    kw_char = 8'h49;
			3'd5:    kw_char = 8'h4F;
			3'd6:    kw_char = 8'h4E;
			default: kw_char = 8'h00;
		endcase
	endfunction

	// Letters of the known attribute names: PATH, DOMAIN, PORT.
	function automatic logic [7:0] an_char(input logic [1:0] k, input logic [2:0] i);
		logic [47:0] txt;
		case (k)
			2'd0:    txt = {8'h50, 8'h41, 8'h54, 8'h48, 8'h00, 8'h00};
			2'd1:    txt = {8'h44, 8'h4F, 8'h4D, 8'h41, 8'h49, 8'h4E};
			2'd2:    txt = {8'h50, 8'h4F, 8'h52, 8'h54, 8'h00, 8'h00};
			default: txt = '0;
		endcase
		case (i)
			3'd0:    an_char = txt[47:40];
			3'd1:    an_char = txt[39:32];
			3'd2:    an_char = txt[31:24];
			3'd3:    an_char = txt[23:16];
			3'd4:    an_char = txt[15:8];
			3'd5:    an_char = txt[7:0];
			default: an_char = 8'h00;
		endcase
	endfunction

	function automatic logic [2:0] an_len(input logic [1:0] k);
		an_len = (k == 2'd1) ? 3'd6 : 3'd4;
	endfunction

endpackage

// ----- design/hchp_fifo.sv -----
`timescale 1ns / 1ps
// Small first-in first-out queue of fixed-width words.
// Depends on no package; used between the parser stages and at the output.
module hchp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/hchp_front.sv -----
`timescale 1ns / 1ps
// Front end: takes header bytes and classifies each one for the parser.
// Depends on hchp_pkg.
module hchp_front (
	input  logic            push,
	input  hchp_pkg::in_t   item,
	input  logic            queue_full,
	output logic            full,
	output logic            wr,
	output hchp_pkg::class_t cls
);

	logic [7:0] c;

	assign c    = item.header_byte;
	assign full = queue_full;
	assign wr   = push && !queue_full;

	always_comb begin
		cls.raw    = c;
		cls.ucase  = hchp_pkg::upcase(c);
		cls.last   = item.last_byte;
		cls.blank  = (c == hchp_pkg::CH_SPACE) ||
		             (c >= hchp_pkg::CH_TAB && c <= hchp_pkg::CH_CR);
		cls.dollar = (c == hchp_pkg::CH_DOLLAR);
		cls.semi   = (c == hchp_pkg::CH_SEMI);
		cls.comma  = (c == hchp_pkg::CH_COMMA);
		cls.eq     = (c == hchp_pkg::CH_EQ);
		cls.quote  = (c == hchp_pkg::CH_QUOTE);
	end

endmodule

// ----- design/hchp_back.sv -----
`timescale 1ns / 1ps
// Back end: the parser state machine, one classified byte per cycle while the result queue has room.
// Depends on hchp_pkg.
module hchp_back #(
	parameter int COUNT_WIDTH = hchp_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cls_valid,
	input  hchp_pkg::class_t cls,
	output logic             cls_take,
	input  logic             res_full,
	output logic             res_wr,
	output hchp_pkg::out_t   res
);

	typedef enum logic [4:0] {
		S_START = 5'd0, S_VER = 5'd1, S_VEQ = 5'd2, S_VVAL0 = 5'd3,
		S_VVAL = 5'd4, S_VQ = 5'd5, S_VSEMI = 5'd6, S_NEWC = 5'd7,
		S_NAME0 = 5'd8, S_NAME = 5'd9, S_VAL0 = 5'd10, S_VAL = 5'd11,
		S_VALQ = 5'd12, S_SEMI = 5'd13, S_ATT = 5'd14, S_ANAME = 5'd15,
		S_AVAL0 = 5'd16, S_AVAL = 5'd17, S_AVALQ = 5'd18
	} state_t;

	localparam int EXT_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

	state_t                 state_q, state_n;
	logic [2:0]             kw_q, kw_n;
	logic [2:0]             mask_q, mask_n;
	logic [2:0]             len_q, len_n;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n, cnt_inc;
	logic                   errl_q, errl_n;

	hchp_pkg::role_t role;
	hchp_pkg::err_t  err;
	hchp_pkg::kind_t kind, fin_kind;
	logic            cstart, ndone, vdone, adone;
	logic [EXT_W-1:0] cnt_ext;

	assign cls_take = cls_valid && !res_full;
	assign res_wr   = cls_take;
	assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

	// Kind of the attribute whose name has just been collected.
	always_comb begin
		fin_kind = hchp_pkg::KIND_UNKNOWN;
		if (mask_q[0] && len_q == hchp_pkg::an_len(2'd0)) begin
			fin_kind = hchp_pkg::KIND_PATH;
		end else if (mask_q[1] && len_q == hchp_pkg::an_len(2'd1)) begin
			fin_kind = hchp_pkg::KIND_DOMAIN;
		end else if (mask_q[2] && len_q == hchp_pkg::an_len(2'd2)) begin
			fin_kind = hchp_pkg::KIND_PORT;
		end
	end

	always_comb begin
		state_n = state_q;
		kw_n    = kw_q;
		mask_n  = mask_q;
		len_n   = len_q;
		cnt_n   = cnt_q;
		errl_n  = errl_q;
		role    = hchp_pkg::ROLE_NONE;
		err     = hchp_pkg::ERR_NONE;
		kind    = hchp_pkg::KIND_PATH;
		cstart  = 1'b0;
		ndone   = 1'b0;
		vdone   = 1'b0;
		adone   = 1'b0;

		if (!errl_q) begin
			unique case (state_q)
				S_VER: begin
					if (!(cls.blank && kw_q == '0)) begin
						if (cls.last && kw_q < hchp_pkg::KW_LAST) begin
							err    = hchp_pkg::ERR_INCOMPL;
							errl_n = 1'b1;
						end else if (cls.ucase != hchp_pkg::kw_char(kw_q)) begin
							err    = hchp_pkg::ERR_EXP_VER;
							errl_n = 1'b1;
						end else if (kw_q == hchp_pkg::KW_LAST) begin
							kw_n    = '0;
							state_n = S_VEQ;
						end else begin
							kw_n = kw_q + 1'b1;
						end
					end
				end
				S_VEQ: begin
					if (!cls.blank) begin
						if (cls.eq) begin
							state_n = S_VVAL0;
						end else begin
							err    = hchp_pkg::ERR_EXP_EQ;
							errl_n = 1'b1;
						end
					end
				end
				S_VVAL0, S_VVAL: begin
					if (state_q == S_VVAL0 && cls.blank) begin
						state_n = state_q;
					end else if (state_q == S_VVAL0 && cls.quote) begin
						state_n = S_VQ;
					end else if (cls.semi) begin
						state_n = S_NEWC;
					end else begin
						role    = hchp_pkg::ROLE_VERSION;
						state_n = S_VVAL;
					end
				end
				S_VQ: begin
					if (cls.quote) begin
						state_n = S_VSEMI;
					end else begin
						role = hchp_pkg::ROLE_VERSION;
					end
				end
				S_VSEMI: begin
					if (!cls.blank) begin
						if (cls.semi) begin
							state_n = S_NEWC;
						end else begin
							err    = hchp_pkg::ERR_EXP_SEMI;
							errl_n = 1'b1;
						end
					end
				end
				S_NAME0, S_NAME: begin
					if (state_q == S_NAME || !cls.blank) begin
						if (cls.eq) begin
							ndone   = 1'b1;
							state_n = S_VAL0;
						end else begin
							role    = hchp_pkg::ROLE_NAME;
							state_n = S_NAME;
						end
					end
				end
				S_VAL0, S_VAL: begin
					if (state_q == S_VAL0 && cls.blank) begin
						state_n = state_q;
					end else if (state_q == S_VAL0 && cls.quote) begin
						state_n = S_VALQ;
					end else if (cls.semi) begin
						vdone   = 1'b1;
						state_n = S_ATT;
					end else begin
						role    = hchp_pkg::ROLE_VALUE;
						state_n = S_VAL;
						vdone   = cls.last;
					end
				end
				S_VALQ: begin
					if (cls.quote) begin
						vdone   = 1'b1;
						state_n = S_SEMI;
					end else begin
						role = hchp_pkg::ROLE_VALUE;
					end
				end
				S_ANAME: begin
					if (cls.eq) begin
						state_n = S_AVAL0;
					end else if (!cls.blank) begin
						role = hchp_pkg::ROLE_ATTR_NAME;
						for (int k = 0; k < 3; k++) begin
							if (len_q >= hchp_pkg::an_len(2'(k)) ||
							    hchp_pkg::an_char(2'(k), len_q) != cls.ucase) begin
								mask_n[k] = 1'b0;
							end
						end
						if (len_q != 3'd7) begin
							len_n = len_q + 1'b1;
						end
					end
				end
				S_AVAL0, S_AVAL: begin
					if (state_q == S_AVAL0 && cls.quote) begin
						state_n = S_AVALQ;
					end else if (state_q == S_AVAL0 && cls.blank) begin
						state_n = state_q;
					end else if (cls.semi) begin
						adone   = 1'b1;
						kind    = fin_kind;
						state_n = S_ATT;
					end else if (cls.blank) begin
						adone   = 1'b1;
						kind    = fin_kind;
						state_n = S_SEMI;
					end else begin
						role    = hchp_pkg::ROLE_ATTR_VAL;
						state_n = S_AVAL;
						if (cls.last) begin
							adone = 1'b1;
							kind  = fin_kind;
							vdone = 1'b1;
						end
					end
				end
				S_AVALQ: begin
					if (cls.quote) begin
						adone   = 1'b1;
						kind    = fin_kind;
						state_n = S_SEMI;
					end else begin
						role = hchp_pkg::ROLE_ATTR_VAL;
					end
				end
				default: begin
					// Start of header, new cookie, after a value or before an attribute.
					if (state_q == S_SEMI && cls.semi) begin
						state_n = S_ATT;
					end else if (state_q == S_SEMI && cls.comma && !cls.blank) begin
						state_n = S_NEWC;
					end else if (state_q == S_ATT && cls.dollar) begin
						mask_n  = '1;
						len_n   = '0;
						state_n = S_ANAME;
					end else if (state_q != S_NEWC && state_q != S_SEMI &&
					             state_q != S_ATT && cls.dollar) begin
						kw_n    = '0;
						state_n = S_VER;
					end else if (state_q == S_NEWC || !cls.blank) begin
						cnt_n  = cnt_inc;
						cstart = 1'b1;
						if (cls.blank) begin
							state_n = S_NAME0;
						end else if (cls.eq) begin
							ndone   = 1'b1;
							state_n = S_VAL0;
						end else begin
							role    = hchp_pkg::ROLE_NAME;
							state_n = S_NAME;
						end
					end
				end
			endcase
		end

		if (cls.last) begin
			state_n = S_START;
			kw_n    = '0;
			mask_n  = '1;
			len_n   = '0;
			errl_n  = 1'b0;
		end
	end

	assign cnt_ext = EXT_W'(cnt_n);

	always_comb begin
		res.char_out     = (role == hchp_pkg::ROLE_ATTR_NAME) ? cls.ucase : cls.raw;
		res.char_role    = role;
		res.cookie_start = cstart;
		res.name_done    = ndone;
		res.value_done   = vdone;
		res.attr_done    = adone;
		res.attr_kind    = adone ? kind : hchp_pkg::KIND_PATH;
		res.error_code   = err;
		res.header_end   = cls.last;
		res.cookie_index = (cnt_ext > EXT_W'(8'hFF)) ? 8'hFF : cnt_ext[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			kw_q    <= '0;
			mask_q  <= '1;
			len_q   <= '0;
			cnt_q   <= '0;
			errl_q  <= 1'b0;
		end else if (cls_take) begin
			state_q <= state_n;
			kw_q    <= kw_n;
			mask_q  <= mask_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			errl_q  <= errl_n;
		end
	end

endmodule

// ----- design/http_cookie_header_parser.sv -----
`timescale 1ns / 1ps
// Cookie header parser, top level. Depends on hchp_pkg, hchp_front, hchp_fifo, hchp_back.
// A byte transferred in is written into the class queue; the parser reads it from the queue head,
// and its result is registered in the result queue, whose head drives the result ports.
// Throughput: one byte per cycle while the result queue has room.
// Reset (arst_n low): both queues empty, parser at start of header, cookie count zero.
// The cookie count survives the end of a header; only reset clears it.
module http_cookie_header_parser #(
	parameter int COUNT_WIDTH = hchp_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = hchp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  hchp_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output hchp_pkg::out_t result
);

	// The front end classifies each byte on its way into the class queue, so the
	// parser sees ready-made character flags. A transfer happens whenever the
	// class queue has room; it does not wait on the result side.
	hchp_pkg::class_t front_cls, back_cls;
	logic             front_wr, cls_full, cls_empty, cls_take;

	// The back end retires one queued byte per cycle while the result queue has
	// room, and writes its result there. The result queue is what the consumer
	// sees: its head is on the result ports while empty is low.
	hchp_pkg::out_t back_res;
	logic           back_wr, res_full;

	hchp_front u_front (
		.push       (push),
		.item       (item),
		.queue_full (cls_full),
		.full       (full),
		.wr         (front_wr),
		.cls        (front_cls)
	);

	hchp_fifo #(
		.WIDTH ($bits(hchp_pkg::class_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cls_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_wr),
		.wdata  (front_cls),
		.full   (cls_full),
		.pop    (cls_take),
		.rdata  (back_cls),
		.empty  (cls_empty)
	);

	hchp_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (!cls_empty),
		.cls       (back_cls),
		.cls_take  (cls_take),
		.res_full  (res_full),
		.res_wr    (back_wr),
		.res       (back_res)
	);

	hchp_fifo #(
		.WIDTH ($bits(hchp_pkg::out_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_wr),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ----- design/hchp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the cookie header parser, bound to the top level.
// Depends on hchp_pkg and http_cookie_header_parser.
module hchp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input hchp_pkg::out_t result
);

	// A waiting result that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.attr_done |-> result.attr_kind == hchp_pkg::KIND_PATH)
		else $error("attribute kind without completed attribute");

	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.char_role == hchp_pkg::ROLE_ATTR_NAME
		|-> !(result.char_out >= 8'h61 && result.char_out <= 8'h7A))
		else $error("attribute name byte not uppercased");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.error_code != hchp_pkg::ERR_NONE
		|-> !result.cookie_start && !result.name_done && !result.value_done &&
		    !result.attr_done && result.char_role == hchp_pkg::ROLE_NONE)
		else $error("error byte carries other events");

endmodule

bind http_cookie_header_parser hchp_checker u_hchp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
